// ----- sv/ktl_pkg.sv -----
// Shared types and constants of the keyword token lexer.
package ktl_pkg;

    localparam int KW_COUNT = 22;
    localparam int KW_LEN   = 7;

    typedef enum logic [11:0] {
        M_IDLE    = 12'b0000_0000_0001,
        M_IDENT   = 12'b0000_0000_0010,
        M_INT     = 12'b0000_0000_0100,
        M_DOT     = 12'b0000_0000_1000,
        M_FRAC    = 12'b0000_0001_0000,
        M_COMMENT = 12'b0000_0010_0000,
        M_MINUS   = 12'b0000_0100_0000,
        M_COLON   = 12'b0000_1000_0000,
        M_EQ      = 12'b0001_0000_0000,
        M_LT      = 12'b0010_0000_0000,
        M_GT      = 12'b0100_0000_0000,
        M_BANG    = 12'b1000_0000_0000
    } mode_t;

    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_ERR    = 6'd1;
    localparam logic [5:0] K_ID     = 6'd2;
    localparam logic [5:0] K_NUM    = 6'd3;
    localparam logic [5:0] K_KW0    = 6'd4;
    localparam logic [5:0] K_LPAREN = 6'd26;
    localparam logic [5:0] K_RPAREN = 6'd27;
    localparam logic [5:0] K_LBRACK = 6'd28;
    localparam logic [5:0] K_RBRACK = 6'd29;
    localparam logic [5:0] K_LBRACE = 6'd30;
    localparam logic [5:0] K_RBRACE = 6'd31;
    localparam logic [5:0] K_COLON  = 6'd32;
    localparam logic [5:0] K_SEMI   = 6'd33;
    localparam logic [5:0] K_COMMA  = 6'd34;
    localparam logic [5:0] K_DOT    = 6'd35;
    localparam logic [5:0] K_EQUALS = 6'd36;
    localparam logic [5:0] K_NEQ    = 6'd37;
    localparam logic [5:0] K_LT     = 6'd38;
    localparam logic [5:0] K_GT     = 6'd39;
    localparam logic [5:0] K_LE     = 6'd40;
    localparam logic [5:0] K_GE     = 6'd41;
    localparam logic [5:0] K_PLUS   = 6'd42;
    localparam logic [5:0] K_MINUS  = 6'd43;
    localparam logic [5:0] K_STAR   = 6'd44;
    localparam logic [5:0] K_SLASH  = 6'd45;
    localparam logic [5:0] K_CARET  = 6'd46;
    localparam logic [5:0] K_ARROW  = 6'd47;
    localparam logic [5:0] K_PIPE   = 6'd48;

    // keyword text, first letter in the low byte, zero padded
    localparam logic [KW_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        56'h6d_65_72_6f_65_68_74, 56'h61_6d_6d_65_6c, 56'h66_65_64,
        56'h6d_6f_69_78_61, 56'h66_6f_6f_72_70, 56'h79_62, 56'h64_6e_65,
        56'h66_69, 56'h6e_65_68_74, 56'h65_73_6c_65, 56'h74_65_6c,
        56'h6e_69, 56'h6c_6c_61_72_6f_66, 56'h73_74_73_69_78_65,
        56'h6e_75_66, 56'h65_75_72_74, 56'h65_73_6c_61_66, 56'h74_6f_6e,
        56'h64_6e_61, 56'h72_6f, 56'h73_65_69_6c_70_6d_69, 56'h66_66_69
    };
    localparam logic [2:0] KW_LENS [KW_COUNT] = '{
        3'd7, 3'd5, 3'd3, 3'd5, 3'd5, 3'd2, 3'd3, 3'd2, 3'd4, 3'd4, 3'd3,
        3'd2, 3'd6, 3'd6, 3'd3, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd7, 3'd3
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == 8'h5f;
    endfunction

endpackage

// ----- sv/keyword_token_lexer_top.sv -----
// Top level of the keyword token lexer.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+-------------------------------------------
//  input   | text_valid | text_stall | text_byte
//  output  | tok_valid  | tok_stall  | token_kind, token_start, token_length,
//          |            |            | line_after, column_after, last_of_run
//
// Each accepted byte is decoded in the cycle it is taken: the mode register and
// the position counters update at that edge and the zero to three tokens it
// closes enter a four-entry result queue. One byte per cycle is sustained while
// tokens drain; a byte that yields several tokens holds input off until the
// queue has room for three again, so the rate is one byte per cycle or one
// token per cycle, whichever is lower. Reset clears the mode, the counters and
// the queue; line and column restart at one. Stall on the output only holds the
// queue head; input stall follows queue occupancy.
module keyword_token_lexer_top #(
    parameter int KEYWORD_MAX_LEN = 7,
    parameter int POSITION_BITS   = 16,
    parameter int OFFSET_BITS     = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_stall,
    input  logic [7:0]  text_byte,
    output logic        tok_valid,
    input  logic        tok_stall,
    output logic [5:0]  token_kind,
    output logic [31:0] token_start,
    output logic [15:0] token_length,
    output logic [15:0] line_after,
    output logic [15:0] column_after,
    output logic        last_of_run
);
    logic             room;
    logic             take;
    logic [2:0]       n_tok;
    logic [2:0][5:0]  kinds;
    logic [2:0][31:0] starts;
    logic [2:0][15:0] lens, lines, cols;

    // accept a byte only while the queue can swallow a full group
    assign text_stall = !room;
    assign take       = text_valid && room;

    ktl_core #(
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
        .POSITION_BITS(POSITION_BITS),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_core (
        .clk(clk), .rst_n(rst_n), .step(take), .c(text_byte),
        .n_tok(n_tok), .kinds(kinds), .starts(starts), .lens(lens),
        .lines(lines), .cols(cols)
    );

    ktl_outq u_q (
        .clk(clk), .rst_n(rst_n), .load(take), .n_tok(n_tok),
        .kinds(kinds), .starts(starts), .lens(lens), .lines(lines), .cols(cols),
        .room(room), .out_valid(tok_valid), .out_stall(tok_stall),
        .token_kind(token_kind), .token_start(token_start),
        .token_length(token_length), .line_after(line_after),
        .column_after(column_after), .last_of_run(last_of_run)
    );
endmodule

// ----- sv/ktl_kwmatch.sv -----
// Parallel keyword compare of the held word.
module ktl_kwmatch #(
    parameter int KEYWORD_MAX_LEN = 7
) (
    input  logic [KEYWORD_MAX_LEN-1:0][7:0] word,
    input  logic [15:0]                     word_len,
    output logic [5:0]                      kind
);
    import ktl_pkg::*;

    logic [KW_COUNT-1:0] hit;

    always_comb
    begin
        for (int i = 0; i < KW_COUNT; i++)
        begin
            hit[i] = (word_len == 16'(KW_LENS[i]));
            for (int j = 0; j < KW_LEN; j++)
            begin
                if (j < int'(KW_LENS[i]) && word[j] != KW_TEXT[i][j*8 +: 8])
                    hit[i] = 1'b0;
            end
        end
        kind = K_ID;
        for (int i = KW_COUNT - 1; i >= 0; i--)
        begin
            if (hit[i])
                kind = K_KW0 + 6'(i);
        end
    end
endmodule

// ----- sv/ktl_core.sv -----
// Lexer state, token decisions and up to three result slots.
module ktl_core #(
    parameter int KEYWORD_MAX_LEN = 7,
    parameter int POSITION_BITS   = 16,
    parameter int OFFSET_BITS     = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  c,
    output logic [2:0]  n_tok,
    output logic [2:0][5:0]  kinds,
    output logic [2:0][31:0] starts,
    output logic [2:0][15:0] lens,
    output logic [2:0][15:0] lines,
    output logic [2:0][15:0] cols
);
    import ktl_pkg::*;

    localparam logic [POSITION_BITS-1:0] PMAX = '1;

    mode_t                          mode_reg, mode_next;
    logic [KEYWORD_MAX_LEN-1:0][7:0] word_reg, word_next;
    logic [15:0]                    wlen_reg, wlen_next;
    logic [OFFSET_BITS-1:0]         beg_reg, beg_next;
    logic [OFFSET_BITS-1:0]         off_reg, off_next;
    logic [POSITION_BITS-1:0]       line_reg, line_next;
    logic [POSITION_BITS-1:0]       col_reg, col_next;
    logic [5:0]                     kw_kind;
    logic [5:0]                     word_kind;
    logic                           absorbed;

    ktl_kwmatch #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_kw (
        .word(word_reg), .word_len(wlen_reg), .kind(kw_kind)
    );

    assign word_kind = (wlen_reg > 16'(KEYWORD_MAX_LEN)) ? K_ID : kw_kind;

    function automatic logic [15:0] sat(input logic [POSITION_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFFFF) ? 16'hFFFF : w[15:0];
    endfunction

    always_comb
    begin
        mode_next = mode_reg;
        word_next = word_reg;
        wlen_next = wlen_reg;
        beg_next  = beg_reg;
        off_next  = off_reg;
        line_next = line_reg;
        col_next  = col_reg;
        n_tok     = '0;
        kinds     = '0;
        starts    = '0;
        lens      = '0;
        lines     = '0;
        cols      = '0;
        absorbed  = 1'b0;

        // emit, count and append as in-order side effects
        begin : body
            logic [5:0]  ek;
            logic [OFFSET_BITS-1:0] es;
            logic [15:0] el;
            logic        do_emit;
            logic        do_cnt;
            logic        lone_dot;

            ek = '0; es = '0; el = '0; do_emit = 1'b0; do_cnt = 1'b0;
            lone_dot = 1'b0;

            if (step)
            begin
                mode_next = M_IDLE;
                unique case (mode_reg)
                    M_IDENT:
                    begin
                        if (is_word(c))
                        begin
                            absorbed = 1'b1; do_cnt = 1'b1; mode_next = M_IDENT;
                        end
                        else
                        begin
                            do_emit = 1'b1; ek = word_kind; es = beg_reg; el = wlen_reg;
                        end
                    end
                    M_INT, M_FRAC:
                    begin
                        if (is_digit(c))
                        begin
                            absorbed = 1'b1; do_cnt = 1'b1; mode_next = mode_reg;
                        end
                        else if (mode_reg == M_INT && c == 8'h2e)
                        begin
                            absorbed = 1'b1; mode_next = M_DOT;
                        end
                        else
                        begin
                            do_emit = 1'b1; ek = K_NUM; es = beg_reg; el = wlen_reg;
                        end
                    end
                    M_DOT:
                    begin
                        if (is_digit(c))
                        begin
                            absorbed = 1'b1; mode_next = M_FRAC;
                        end
                        else
                        begin
                            do_emit = 1'b1; ek = K_NUM; es = beg_reg; el = wlen_reg;
                            lone_dot = 1'b1;
                        end
                    end
                    M_COMMENT:
                    begin
                        if (c != 8'h0a && c != 8'h00)
                        begin
                            absorbed = 1'b1; do_cnt = 1'b1; mode_next = M_COMMENT;
                        end
                    end
                    M_MINUS:
                    begin
                        if (c == 8'h2d)
                        begin
                            absorbed = 1'b1; do_cnt = 1'b1; mode_next = M_COMMENT;
                        end
                        else if (c == 8'h3e)
                        begin
                            absorbed = 1'b1; do_cnt = 1'b1;
                            do_emit = 1'b1; ek = K_ARROW; es = beg_reg; el = 16'd2;
                        end
                        else
                        begin
                            do_emit = 1'b1; ek = K_MINUS; es = beg_reg; el = 16'd1;
                        end
                    end
                    M_COLON, M_EQ, M_LT, M_GT, M_BANG:
                    begin
                        do_emit = 1'b1; es = beg_reg;
                        if (c == 8'h3d)
                        begin
                            absorbed = 1'b1; do_cnt = 1'b1; el = 16'd2;
                            unique case (mode_reg)
                                M_LT:    ek = K_LE;
                                M_GT:    ek = K_GE;
                                M_BANG:  ek = K_NEQ;
                                default: ek = K_EQUALS;
                            endcase
                        end
                        else
                        begin
                            el = 16'd1;
                            unique case (mode_reg)
                                M_COLON: ek = K_COLON;
                                M_EQ:    ek = K_EQUALS;
                                M_LT:    ek = K_LT;
                                M_GT:    ek = K_GT;
                                default: ek = K_ERR;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end

            // slot 0: pending token (its position is taken after any count)
            if (step && mode_reg == M_DOT && is_digit(c))
            begin
                // dot and digit both join the number
                off_next = off_reg + OFFSET_BITS'(2);
                col_next = (col_reg >= PMAX - 1) ? PMAX : col_reg + 1'b1 + 1'b1;
                if (col_reg == PMAX) col_next = PMAX;
                for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                begin
                    if (16'(i) == wlen_reg) word_next[i] = 8'h2e;
                    if (16'(i) == wlen_reg + 16'd1) word_next[i] = c;
                end
                wlen_next = (wlen_reg >= 16'hFFFE) ? 16'hFFFF : wlen_reg + 16'd2;
            end
            else if (do_cnt)
            begin
                off_next = off_reg + 1'b1;
                if (c == 8'h0a)
                begin
                    if (line_reg != PMAX) line_next = line_reg + 1'b1;
                    col_next = POSITION_BITS'(1);
                end
                else if (col_reg != PMAX)
                    col_next = col_reg + 1'b1;
                if (mode_reg == M_IDENT || mode_reg == M_INT || mode_reg == M_FRAC)
                begin
                    for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                        if (16'(i) == wlen_reg) word_next[i] = c;
                    if (wlen_reg != 16'hFFFF) wlen_next = wlen_reg + 16'd1;
                end
            end

            if (do_emit)
            begin
                kinds[0]  = ek;
                starts[0] = 32'(es);
                lens[0]   = el;
                lines[0]  = sat(line_next);
                cols[0]   = sat(col_next);
                n_tok     = 3'd1;
            end

            if (lone_dot)
            begin
                // count the held dot, then emit it as its own token
                kinds[1]  = K_DOT;
                starts[1] = 32'(off_reg);
                lens[1]   = 16'd1;
                beg_next  = off_reg;
                off_next  = off_reg + 1'b1;
                if (col_reg != PMAX) col_next = col_reg + 1'b1;
                lines[1]  = sat(line_next);
                cols[1]   = sat(col_next);
                n_tok     = 3'd2;
            end

            // fresh byte when the pending mode did not absorb it
            if (step && !absorbed)
            begin
                logic [OFFSET_BITS-1:0] o;
                logic [POSITION_BITS-1:0] ln, cl;
                logic [5:0] sk;
                logic       single;
                o  = off_next;
                ln = line_next;
                cl = col_next;
                sk = K_ERR;
                single = 1'b0;
                if (c == 8'h00)
                begin
                    kinds[n_tok[1:0]]  = K_EOF;
                    starts[n_tok[1:0]] = 32'(o);
                    lens[n_tok[1:0]]   = 16'd0;
                    lines[n_tok[1:0]]  = sat(ln);
                    cols[n_tok[1:0]]   = sat(cl);
                    n_tok = n_tok + 3'd1;
                    mode_next = M_IDLE;
                    wlen_next = '0;
                    beg_next  = '0;
                    off_next  = '0;
                    line_next = POSITION_BITS'(1);
                    col_next  = POSITION_BITS'(1);
                end
                else
                begin
                    off_next = o + 1'b1;
                    if (c == 8'h0a)
                    begin
                        if (ln != PMAX) line_next = ln + 1'b1;
                        col_next = POSITION_BITS'(1);
                    end
                    else if (cl != PMAX)
                        col_next = cl + 1'b1;
                    if (c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a)
                        ;
                    else if (is_alpha(c) || c == 8'h5f || is_digit(c))
                    begin
                        beg_next = o;
                        word_next[0] = c;
                        wlen_next = 16'd1;
                        mode_next = is_digit(c) ? M_INT : M_IDENT;
                    end
                    else
                    begin
                        beg_next = o;
                        single = 1'b1;
                        unique case (c)
                            8'h28: sk = K_LPAREN;
                            8'h29: sk = K_RPAREN;
                            8'h5b: sk = K_LBRACK;
                            8'h5d: sk = K_RBRACK;
                            8'h7b: sk = K_LBRACE;
                            8'h7d: sk = K_RBRACE;
                            8'h3b: sk = K_SEMI;
                            8'h2c: sk = K_COMMA;
                            8'h2e: sk = K_DOT;
                            8'h2b: sk = K_PLUS;
                            8'h2a: sk = K_STAR;
                            8'h2f: sk = K_SLASH;
                            8'h5e: sk = K_CARET;
                            8'h7c: sk = K_PIPE;
                            8'h2d: begin mode_next = M_MINUS; single = 1'b0; end
                            8'h3a: begin mode_next = M_COLON; single = 1'b0; end
                            8'h3d: begin mode_next = M_EQ;    single = 1'b0; end
                            8'h3c: begin mode_next = M_LT;    single = 1'b0; end
                            8'h3e: begin mode_next = M_GT;    single = 1'b0; end
                            8'h21: begin mode_next = M_BANG;  single = 1'b0; end
                            default: sk = K_ERR;
                        endcase
                        if (single)
                        begin
                            kinds[n_tok[1:0]]  = sk;
                            starts[n_tok[1:0]] = 32'(o);
                            lens[n_tok[1:0]]   = 16'd1;
                            lines[n_tok[1:0]]  = sat(line_next);
                            cols[n_tok[1:0]]   = sat(col_next);
                            n_tok = n_tok + 3'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            wlen_reg <= '0;
            beg_reg  <= '0;
            off_reg  <= '0;
            line_reg <= POSITION_BITS'(1);
            col_reg  <= POSITION_BITS'(1);
        end
        else
        begin
            mode_reg <= mode_next;
            wlen_reg <= wlen_next;
            beg_reg  <= beg_next;
            off_reg  <= off_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0 && col_reg != '0)
        else $error("line or column counter reached zero");
    a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
        step && c == 8'h00 |=> off_reg == '0 && mode_reg == M_IDLE)
        else $error("end of text did not rewind");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_tok <= 3'd3)
        else $error("more than three tokens in one step");
endmodule

// ----- sv/ktl_outq.sv -----
// Result queue that turns a group of tokens into single transactions.
module ktl_outq (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [2:0]  n_tok,
    input  logic [2:0][5:0]  kinds,
    input  logic [2:0][31:0] starts,
    input  logic [2:0][15:0] lens,
    input  logic [2:0][15:0] lines,
    input  logic [2:0][15:0] cols,
    output logic        room,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_kind,
    output logic [31:0] token_start,
    output logic [15:0] token_length,
    output logic [15:0] line_after,
    output logic [15:0] column_after,
    output logic        last_of_run
);
    // four-entry ring; a group is loaded only with room for three
    logic [3:0][5:0]  k_reg;
    logic [3:0][31:0] s_reg;
    logic [3:0][15:0] l_reg, ln_reg, c_reg;
    logic [3:0]       last_reg;
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid = cnt_reg != '0;
    assign pop       = out_valid && !out_stall;
    assign room      = (cnt_reg - 3'(pop)) <= 3'd1;

    assign token_kind   = k_reg[rd_reg];
    assign token_start  = s_reg[rd_reg];
    assign token_length = l_reg[rd_reg];
    assign line_after   = ln_reg[rd_reg];
    assign column_after = c_reg[rd_reg];
    assign last_of_run  = last_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg - 3'(pop) + (load ? n_tok : 3'd0);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (3'(i) < n_tok)
                begin
                    k_reg[wr_reg + 2'(i)]    <= kinds[i];
                    s_reg[wr_reg + 2'(i)]    <= starts[i];
                    l_reg[wr_reg + 2'(i)]    <= lens[i];
                    ln_reg[wr_reg + 2'(i)]   <= lines[i];
                    c_reg[wr_reg + 2'(i)]    <= cols[i];
                    last_reg[wr_reg + 2'(i)] <= (3'(i) == n_tok - 3'd1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (pop) rd_reg <= rd_reg + 2'd1;
            if (load) wr_reg <= wr_reg + n_tok[1:0];
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("result queue overflow");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !load |=> cnt_reg == $past(cnt_reg) - 3'd1)
        else $error("queue count lost a transaction");
    a_room_rule: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> room)
        else $error("group loaded without room");
endmodule

// ----- test/tb_keyword_token_lexer_top.sv -----
// Self-checking testbench of the keyword token lexer: directed table, then random text.
module tb_keyword_token_lexer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ktl_pkg::*;

    localparam int KW_MAX      = 7;
    localparam int WATCHDOG    = 4000;
    localparam int DRAIN_WAIT  = 20;
    localparam int RANDOM_BYTES = 400;
    localparam logic [5:0] KIND_NONE = 6'd63; // table row with no typed-in kind

    // one token as the block reports it
    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } token_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        text_valid = 1'b0;
    logic        text_stall;
    logic [7:0]  text_byte = 8'd0;
    logic        tok_valid;
    logic        tok_stall = 1'b0;
    logic [5:0]  token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_after;
    logic [15:0] column_after;
    logic        last_of_run;

    keyword_token_lexer_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .text_valid(text_valid), .text_stall(text_stall), .text_byte(text_byte),
        .tok_valid(tok_valid), .tok_stall(tok_stall),
        .token_kind(token_kind), .token_start(token_start), .token_length(token_length),
        .line_after(line_after), .column_after(column_after), .last_of_run(last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Tokenizer prediction: its own copy of the scan state
    // ---------------------------------------------------------------
    mode_t       lex_mode = M_IDLE;
    logic [7:0]  lex_word [KW_MAX];
    logic [15:0] lex_wlen = '0;
    logic [31:0] lex_begin = '0;
    logic [31:0] lex_offset = '0;
    logic [15:0] lex_line = 16'd1;
    logic [15:0] lex_col = 16'd1;

    token_t expected_tokens [$];
    token_t step_tokens [$];

    bit failed = 1'b0;
    bit hold_off = 1'b0;
    int idle_cycles = 0;

    function automatic bit alpha_c(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit digit_c(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit wordch(logic [7:0] c);
        return alpha_c(c) || digit_c(c) || c == "_";
    endfunction

    function automatic void advance_position(logic [7:0] c);
        lex_offset = lex_offset + 1;
        if (c == 8'h0a)
        begin
            if (lex_line != 16'hffff) lex_line = lex_line + 1;
            lex_col = 16'd1;
        end
        else if (lex_col != 16'hffff)
            lex_col = lex_col + 1;
    endfunction

    function automatic void push_token(logic [5:0] kind, logic [31:0] start, logic [15:0] len);
        token_t t;
        t.kind = kind;
        t.start = start;
        t.len = len;
        t.line = lex_line;
        t.col = lex_col;
        t.last = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void word_add(logic [7:0] c);
        if (lex_wlen < KW_MAX) lex_word[lex_wlen] = c;
        if (lex_wlen != 16'hffff) lex_wlen = lex_wlen + 1;
    endfunction

    // keyword table held as plain strings, independent of the package encoding
    function automatic logic [5:0] classify_word();
        string names [22] = '{"theorem", "lemma", "def", "axiom", "proof", "by", "end",
            "if", "then", "else", "let", "in", "forall", "exists", "fun", "true",
            "false", "not", "and", "or", "implies", "iff"};
        bit same;
        if (lex_wlen > KW_MAX) return K_ID;
        for (int i = 0; i < 22; i++)
        begin
            same = (lex_wlen == names[i].len());
            for (int j = 0; same && j < names[i].len(); j++)
                if (lex_word[j] != names[i][j]) same = 1'b0;
            if (same) return K_KW0 + 6'(i);
        end
        return K_ID;
    endfunction

    // close or extend the pending token; returns 1 when the byte is absorbed
    function automatic bit close_pending(logic [7:0] c);
        mode_t m = lex_mode;
        logic [5:0] one, two;
        lex_mode = M_IDLE;
        case (m)
            M_IDENT:
            begin
                if (wordch(c))
                begin
                    word_add(c); advance_position(c); lex_mode = M_IDENT; return 1;
                end
                push_token(classify_word(), lex_begin, lex_wlen);
                return 0;
            end
            M_INT, M_FRAC:
            begin
                if (digit_c(c))
                begin
                    word_add(c); advance_position(c); lex_mode = m; return 1;
                end
                if (m == M_INT && c == ".")
                begin
                    lex_mode = M_DOT; return 1;
                end
                push_token(K_NUM, lex_begin, lex_wlen);
                return 0;
            end
            M_DOT:
            begin
                if (digit_c(c))
                begin
                    advance_position("."); advance_position(c);
                    word_add("."); word_add(c);
                    lex_mode = M_FRAC;
                    return 1;
                end
                push_token(K_NUM, lex_begin, lex_wlen);
                lex_begin = lex_offset;
                advance_position(".");
                push_token(K_DOT, lex_begin, 16'd1);
                return 0;
            end
            M_COMMENT:
            begin
                if (c != 8'h0a && c != 8'h00)
                begin
                    advance_position(c); lex_mode = M_COMMENT; return 1;
                end
                return 0;
            end
            M_MINUS:
            begin
                if (c == "-")
                begin
                    advance_position(c); lex_mode = M_COMMENT; return 1;
                end
                if (c == ">")
                begin
                    advance_position(c); push_token(K_ARROW, lex_begin, 16'd2); return 1;
                end
                push_token(K_MINUS, lex_begin, 16'd1);
                return 0;
            end
            M_COLON, M_EQ, M_LT, M_GT, M_BANG:
            begin
                one = (m == M_COLON) ? K_COLON : (m == M_EQ) ? K_EQUALS :
                      (m == M_LT) ? K_LT : (m == M_GT) ? K_GT : K_ERR;
                two = (m == M_COLON || m == M_EQ) ? K_EQUALS :
                      (m == M_LT) ? K_LE : (m == M_GT) ? K_GE : K_NEQ;
                if (c == "=")
                begin
                    advance_position(c); push_token(two, lex_begin, 16'd2); return 1;
                end
                push_token(one, lex_begin, 16'd1);
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    function automatic void open_symbol(logic [7:0] c);
        logic [5:0] kind;
        lex_begin = lex_offset;
        advance_position(c);
        case (c)
            "(": kind = K_LPAREN;
            ")": kind = K_RPAREN;
            "[": kind = K_LBRACK;
            "]": kind = K_RBRACK;
            "{": kind = K_LBRACE;
            "}": kind = K_RBRACE;
            ";": kind = K_SEMI;
            ",": kind = K_COMMA;
            ".": kind = K_DOT;
            "+": kind = K_PLUS;
            "*": kind = K_STAR;
            "/": kind = K_SLASH;
            "^": kind = K_CARET;
            "|": kind = K_PIPE;
            "-": begin lex_mode = M_MINUS; return; end
            ":": begin lex_mode = M_COLON; return; end
            "=": begin lex_mode = M_EQ; return; end
            "<": begin lex_mode = M_LT; return; end
            ">": begin lex_mode = M_GT; return; end
            "!": begin lex_mode = M_BANG; return; end
            default: kind = K_ERR;
        endcase
        push_token(kind, lex_begin, 16'd1);
    endfunction

    // work out the tokens one byte yields and queue them
    function automatic void predict_tokens(logic [7:0] c);
        step_tokens.delete();
        if (!close_pending(c))
        begin
            if (c == 8'h00)
            begin
                push_token(K_EOF, lex_offset, 16'd0);
                lex_mode = M_IDLE;
                lex_wlen = '0;
                lex_begin = '0;
                lex_offset = '0;
                lex_line = 16'd1;
                lex_col = 16'd1;
            end
            else if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a)
                advance_position(c);
            else if (alpha_c(c) || c == "_" || digit_c(c))
            begin
                lex_begin = lex_offset;
                lex_wlen = '0;
                word_add(c);
                advance_position(c);
                lex_mode = digit_c(c) ? M_INT : M_IDENT;
            end
            else
                open_symbol(c);
        end
        if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    // directed text; a typed-in kind is checked on the first predicted token of that byte
    typedef struct {
        logic [7:0] ch;
        logic [5:0] first_kind;
    } row_t;

    row_t directed [] = '{
        '{8'h00, K_EOF},   '{"!", KIND_NONE}, '{" ", K_ERR},   '{"!", KIND_NONE},
        '{"=", K_NEQ},     '{8'hff, K_ERR},   '{8'h80, K_ERR}, '{":", KIND_NONE},
        '{"=", K_EQUALS},  '{"=", KIND_NONE}, '{"=", K_EQUALS},'{"9", KIND_NONE},
        '{".", KIND_NONE}, '{"x", KIND_NONE}, '{"-", KIND_NONE},'{"-", KIND_NONE},
        '{"z", KIND_NONE}, '{8'h0a, KIND_NONE},'{"<", KIND_NONE},'{">", K_LT},
        '{"-", K_GT},      '{">", K_ARROW},   '{"_", KIND_NONE},'{"1", KIND_NONE},
        '{8'h00, KIND_NONE}
    };

    string fragments [] = '{"theorem ", "lemma", "def", "axiom", "proof", "by", "end",
        "if", "then", "else", "let", "in", "forall", "exists", "fun", "true", "false",
        "not", "and", "or", "implies", "iff", "theorems", "x_1", "identifier_long",
        "42", "3.14", "7.", "1..2", ":=", "==", "!=", "<=", ">=", "->", "--c\n", "-- x",
        "()", "[]", "{}", ";", ",", ".", "+", "*", "/", "^", "|", ":", "!", "<", ">",
        " ", "\t", "\r", "\n", "  "};

    logic [7:0] text_queue [$];
    logic [5:0] first_kind_queue [$];

    function automatic void add_random_text(int count);
        string s;
        int n = 0;
        while (n < count)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    text_queue.push_back(8'($urandom_range(0, 255)));
                    first_kind_queue.push_back(KIND_NONE);
                    n++;
                end
                1:
                begin
                    text_queue.push_back(8'h00);
                    first_kind_queue.push_back(KIND_NONE);
                    n++;
                end
                default:
                begin
                    s = fragments[$urandom_range(0, fragments.size() - 1)];
                    for (int i = 0; i < s.len(); i++)
                    begin
                        text_queue.push_back(s[i]);
                        first_kind_queue.push_back(KIND_NONE);
                        n++;
                    end
                end
            endcase
        end
        text_queue.push_back(8'h00);
        first_kind_queue.push_back(KIND_NONE);
    endfunction

    // sender: bursts of offered bytes with random gaps
    initial
    begin
        int burst;
        int gap;
        foreach (directed[i])
        begin
            text_queue.push_back(directed[i].ch);
            first_kind_queue.push_back(directed[i].first_kind);
        end
        add_random_text(RANDOM_BYTES);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (text_queue.size() > 0)
        begin
            burst = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            while (burst > 0 && text_queue.size() > 0)
            begin
                text_valid <= 1'b1;
                text_byte <= text_queue[0];
                @(posedge clk);
                if (!text_stall)
                begin
                    void'(text_queue.pop_front());
                    burst--;
                end
            end
            // drop valid only for a real gap so valid is not toggled in one step
            if (gap > 0)
            begin
                text_valid <= 1'b0;
                text_byte <= 8'($urandom_range(0, 255));
                repeat (gap) @(posedge clk);
            end
        end
        text_valid <= 1'b0;
        while (expected_tokens.size() > 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // receiver: own stall pattern, with one long hold-off while bytes keep coming
    initial
    begin
        int cycle = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle == 150) hold_off = 1'b1;
            if (cycle == 230) hold_off = 1'b0;
            if (hold_off)
                tok_stall <= 1'b1;
            else if ((cycle / 64) % 3 == 0)
                tok_stall <= 1'b0;
            else
                tok_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // ---------------------------------------------------------------
    // Checking: predict on accepted bytes, compare accepted tokens
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        token_t got;
        token_t want;
        bit took_byte;
        took_byte = rst_n && text_valid && !text_stall;
        if (took_byte)
        begin
            predict_tokens(text_byte);
            if (first_kind_queue.size() > 0)
            begin
                if (first_kind_queue[0] != KIND_NONE && step_tokens.size() > 0
                    && step_tokens[0].kind != first_kind_queue[0])
                begin
                    $display("%0t: table kind for byte %h expected %0d actual %0d",
                             $realtime, text_byte, first_kind_queue[0], step_tokens[0].kind);
                    failed = 1'b1;
                end
                void'(first_kind_queue.pop_front());
            end
        end
        if (rst_n && tok_valid && !tok_stall)
        begin
            got = '{token_kind, token_start, token_length, line_after, column_after,
                    last_of_run};
            if (expected_tokens.size() == 0)
            begin
                $display("%0t: unexpected token expected none actual %p", $realtime, got);
                failed = 1'b1;
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (got.kind != want.kind)
                begin
                    $display("%0t: token_kind expected %0d actual %0d", $realtime, want.kind, got.kind);
                    failed = 1'b1;
                end
                if (got.start != want.start)
                begin
                    $display("%0t: token_start expected %0d actual %0d", $realtime, want.start, got.start);
                    failed = 1'b1;
                end
                if (got.len != want.len)
                begin
                    $display("%0t: token_length expected %0d actual %0d", $realtime, want.len, got.len);
                    failed = 1'b1;
                end
                if (got.line != want.line)
                begin
                    $display("%0t: line_after expected %0d actual %0d", $realtime, want.line, got.line);
                    failed = 1'b1;
                end
                if (got.col != want.col)
                begin
                    $display("%0t: column_after expected %0d actual %0d", $realtime, want.col, got.col);
                    failed = 1'b1;
                end
                if (got.last != want.last)
                begin
                    $display("%0t: last_of_run expected %0d actual %0d", $realtime, want.last, got.last);
                    failed = 1'b1;
                end
            end
        end
        // watchdog: count cycles with no transaction on either side
        if (took_byte || (tok_valid && !tok_stall))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule

// ----- sim.f -----
sv/ktl_pkg.sv
sv/ktl_kwmatch.sv
sv/ktl_core.sv
sv/ktl_outq.sv
sv/keyword_token_lexer_top.sv
test/tb_keyword_token_lexer_top.sv
